/* src/presence_bitmask_field_locator_unit_assert.svh */
// Assertion helpers for the field locator. Both sample on the rising edge of clk
// and are switched off while rst_n is low.
`ifndef PRESENCE_BITMASK_FIELD_LOCATOR_UNIT_ASSERT_SVH
`define PRESENCE_BITMASK_FIELD_LOCATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBFL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/pbfl_pkg.sv */
`default_nettype none

package pbfl_pkg;

  // Default number of header bytes skipped at the start of each record.
  localparam int HeaderBytesDflt = 8;

  // Bitmask byte layout: seven slot bits and a continuation flag.
  localparam logic [7:0] SlotBitsMask = 8'h7F;
  localparam int         SlotsPerByte = 7;
  localparam int         ContBit      = 7;

  // Parsing phase of the current record.
  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_MASK   = 6'b000010,
    PH_DRAIN  = 6'b000100,
    PH_SKIP   = 6'b001000,
    PH_OFF_LO = 6'b010000,
    PH_OFF_HI = 6'b100000
  } phase_t;

  // Per-record parsing state.
  typedef struct packed {
    phase_t      phase;
    logic [17:0] byte_count;
    logic [16:0] slots_seen;
    logic [15:0] present_before;
    logic [7:0]  offset_low_byte;
    logic        answered;
  } rec_state_t;

  // Result of one word, passed from the step logic to the result register.
  typedef struct packed {
    logic        emit;
    logic        found;
    logic [32:0] field_offset;
  } result_t;

  // State at the start of every record.
  function automatic rec_state_t rec_start(input logic no_header);
    rec_state_t s;
    s.phase           = no_header ? PH_MASK : PH_HEADER;
    s.byte_count      = '0;
    s.slots_seen      = '0;
    s.present_before  = '0;
    s.offset_low_byte = '0;
    s.answered        = 1'b0;
    return s;
  endfunction

  // Number of set bits among the lowest n of seven slot bits.
  function automatic logic [2:0] pop_below(input logic [6:0] bits, input logic [3:0] n);
    logic [2:0] c;
    c = '0;
    for (int i = 0; i < SlotsPerByte; i++) begin
      if (4'(i) < n) begin
        c = c + 3'(bits[i]);
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/presence_bitmask_field_locator_unit.sv */
`default_nettype none

// Channel   Direction  Word contents
// in_       slave      tdata: data_byte, record_base; tlast: last_byte
// out_      master     tdata: field_offset; tuser: found
// cfg_      write      target_slot
//
// One record byte is taken per cycle while out_ is not stalled.
// A result word appears on out_ in the cycle after the byte that decides it.
// The single result register sets the rate: in_tready falls only while a
// result is held and out_tready is low.
// rst_n (synchronous) clears target_slot and returns the record state to the start of a record.
`include "presence_bitmask_field_locator_unit_assert.svh"

module presence_bitmask_field_locator_unit #(
  parameter int HEADER_BYTES = pbfl_pkg::HeaderBytesDflt
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input record bytes.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [7:0] data_byte, [39:8] record_base
  input  wire logic        in_tlast,   // last_byte
  // Result words.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [32:0] field_offset, [39:33] zero
  output logic             out_tuser,  // [0] found
  // Slot register.
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  localparam logic NoHeader = (HEADER_BYTES == 0);

  pbfl_pkg::rec_state_t st_r;
  pbfl_pkg::rec_state_t st_nxt;
  pbfl_pkg::result_t    res;
  logic [15:0]          target_slot_r;
  logic                 out_valid_r;
  logic                 found_r;
  logic [32:0]          field_offset_r;
  logic                 in_acc;

  // A new byte is taken whenever the result register is free or being emptied.
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // Slot register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_slot_r <= '0;
    end else if (cfg_wr_en) begin
      target_slot_r <= cfg_wr_data;
    end
  end

  pbfl_step #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_step (
    .st_cur      (st_r),
    .target_slot (target_slot_r),
    .data_byte   (in_tdata[7:0]),
    .record_base (in_tdata[39:8]),
    .last_byte   (in_tlast),
    .st_nxt      (st_nxt),
    .res         (res)
  );

  // Record state advances on each accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pbfl_pkg::rec_start(NoHeader);
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_acc && res.emit) begin
      found_r        <= res.found;
      field_offset_r <= res.field_offset;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, field_offset_r};
  assign out_tuser  = found_r;

  // Checks on the block's own behaviour.
  `PBFL_ASSERT_NOW(a_no_overwrite, out_tvalid && !out_tready, !in_tready, "result overwritten")
  `PBFL_ASSERT_NOW(a_miss_zero, out_tvalid && !out_tuser, out_tdata == '0, "miss with offset")
  `PBFL_ASSERT_NEXT(a_rec_restart, in_acc && in_tlast, !st_r.answered && st_r.byte_count == '0,
                    "record state not restarted")
  `PBFL_ASSERT_NEXT(a_one_answer, in_acc && in_tlast && !st_r.answered, out_tvalid,
                    "record ended without a result")

endmodule

`default_nettype wire

/* src/pbfl_step.sv */
`default_nettype none

// Next-state and result logic for one record byte.
module pbfl_step #(
  parameter int HEADER_BYTES = pbfl_pkg::HeaderBytesDflt
) (
  input  wire pbfl_pkg::rec_state_t st_cur,
  input  wire logic [15:0]          target_slot,
  input  wire logic [7:0]           data_byte,
  input  wire logic [31:0]          record_base,
  input  wire logic                 last_byte,
  output pbfl_pkg::rec_state_t      st_nxt,
  output pbfl_pkg::result_t         res
);

  localparam logic [17:0] HdrCount = 18'(HEADER_BYTES);
  localparam logic        NoHeader = (HEADER_BYTES == 0);

  logic [16:0] target_ext;
  logic [16:0] slot_gap;
  logic        in_window;
  logic [6:0]  slot_bits;
  logic        cont;
  logic [17:0] count_inc;
  logic [15:0] pb_part;
  logic [15:0] pb_full;
  logic [17:0] skip_len;
  logic [32:0] hit_offset;

  // Position of the sought slot relative to the current mask byte.
  assign target_ext = {1'b0, target_slot};
  assign slot_gap   = target_ext - st_cur.slots_seen;
  assign in_window  = (target_ext >= st_cur.slots_seen)
                   && (slot_gap < 17'(pbfl_pkg::SlotsPerByte));
  assign slot_bits  = 7'(data_byte & pbfl_pkg::SlotBitsMask);
  assign cont       = data_byte[pbfl_pkg::ContBit];

  // Counters and sums used by several phases.
  assign count_inc  = st_cur.byte_count + 18'd1;
  assign pb_part    = st_cur.present_before
                    + 16'(pbfl_pkg::pop_below(slot_bits, {1'b0, slot_gap[2:0]}));
  assign pb_full    = st_cur.present_before
                    + 16'(pbfl_pkg::pop_below(slot_bits, 4'(pbfl_pkg::SlotsPerByte)));
  assign skip_len   = {1'b0, st_cur.present_before, 1'b0};
  assign hit_offset = {1'b0, record_base} + {17'd0, data_byte, st_cur.offset_low_byte};

  // Phase walk for one byte.
  always_comb begin
    st_nxt           = st_cur;
    res.emit         = 1'b0;
    res.found        = 1'b0;
    res.field_offset = '0;
    if (!st_cur.answered) begin
      case (st_cur.phase)
        pbfl_pkg::PH_HEADER: begin
          st_nxt.byte_count = count_inc;
          if (count_inc >= HdrCount) begin
            st_nxt.phase = pbfl_pkg::PH_MASK;
          end
        end
        pbfl_pkg::PH_MASK: begin
          if (in_window) begin
            if (!slot_bits[slot_gap[2:0]]) begin
              // Sought slot is absent.
              st_nxt.answered = 1'b1;
              res.emit        = 1'b1;
            end else begin
              st_nxt.present_before = pb_part;
              if (cont) begin
                st_nxt.phase = pbfl_pkg::PH_DRAIN;
              end else begin
                st_nxt.byte_count = '0;
                st_nxt.phase = (pb_part == '0) ? pbfl_pkg::PH_OFF_LO : pbfl_pkg::PH_SKIP;
              end
            end
          end else begin
            st_nxt.present_before = pb_full;
            st_nxt.slots_seen     = st_cur.slots_seen + 17'(pbfl_pkg::SlotsPerByte);
            if (!cont) begin
              // Bitmask ended before the sought slot.
              st_nxt.answered = 1'b1;
              res.emit        = 1'b1;
            end
          end
        end
        pbfl_pkg::PH_DRAIN: begin
          if (!cont) begin
            st_nxt.byte_count = '0;
            st_nxt.phase = (st_cur.present_before == '0) ? pbfl_pkg::PH_OFF_LO
                                                          : pbfl_pkg::PH_SKIP;
          end
        end
        pbfl_pkg::PH_SKIP: begin
          st_nxt.byte_count = count_inc;
          if (count_inc >= skip_len) begin
            st_nxt.phase = pbfl_pkg::PH_OFF_LO;
          end
        end
        pbfl_pkg::PH_OFF_LO: begin
          st_nxt.offset_low_byte = data_byte;
          st_nxt.phase           = pbfl_pkg::PH_OFF_HI;
        end
        pbfl_pkg::PH_OFF_HI: begin
          st_nxt.answered  = 1'b1;
          res.emit         = 1'b1;
          res.found        = 1'b1;
          res.field_offset = hit_offset;
        end
        default: begin
          st_nxt.answered = 1'b1;
          res.emit        = 1'b1;
        end
      endcase
      // A record that ends before any answer is reported as not found.
      if (!st_nxt.answered && last_byte) begin
        res.emit = 1'b1;
      end
    end
    // Every record starts afresh after its last byte.
    if (last_byte) begin
      st_nxt = pbfl_pkg::rec_start(NoHeader);
    end
  end

endmodule

`default_nettype wire

/* dv/field_locator_checker.sv */
`timescale 1ns / 100ps

module field_locator_checker #(
  parameter int HEADER_BYTES = pbfl_pkg::HeaderBytesDflt
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] data_byte, [39:8] record_base
  input  logic        in_tlast,   // last_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [32:0] field_offset, [39:33] zero
  input  logic        out_tuser,  // [0] found
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output int          pending,
  output int          mismatches,
  output int          checked
);

  typedef struct packed {
    logic        found;
    logic [32:0] field_offset;
  } locate_result_t;

  // Results still owed by the block, oldest first.
  locate_result_t offset_q[$];

  // Own copy of the slot register and of the per-record parsing state.
  logic [15:0]       slot_sel;
  pbfl_pkg::phase_t  ph;
  logic [17:0]       byte_cnt;
  logic [16:0]       slot_base;
  logic [15:0]       present_cnt;
  logic [7:0]        off_lo;
  logic              done;

  // Set bits among the lowest n of the seven slot bits.
  function automatic logic [15:0] ones_below(input logic [6:0] bits, input int n);
    logic [15:0] c;
    c = '0;
    for (int i = 0; i < 7; i++) begin
      if (i < n && bits[i]) begin
        c = c + 16'd1;
      end
    end
    return c;
  endfunction

  task automatic new_record();
    ph          = (HEADER_BYTES == 0) ? pbfl_pkg::PH_MASK : pbfl_pkg::PH_HEADER;
    byte_cnt    = '0;
    slot_base   = '0;
    present_cnt = '0;
    off_lo      = '0;
    done        = 1'b0;
  endtask

  // The bitmask has ended with the slot present: skip the table, or read the offset at once.
  task automatic close_mask();
    byte_cnt = '0;
    ph       = (present_cnt == 0) ? pbfl_pkg::PH_OFF_LO : pbfl_pkg::PH_SKIP;
  endtask

  // Advance the parser by one record byte and queue the result it decides, if any.
  task automatic advance_locator(input logic [7:0] b, input logic [31:0] base,
                                 input logic is_last);
    logic           emit;
    locate_result_t r;
    logic [31:0]    slot_gap;
    emit = 1'b0;
    r    = '0;
    if (!done) begin
      case (ph)
        pbfl_pkg::PH_HEADER: begin
          byte_cnt = byte_cnt + 18'd1;
          if (byte_cnt >= HEADER_BYTES) ph = pbfl_pkg::PH_MASK;
        end
        pbfl_pkg::PH_MASK: begin
          slot_gap = 32'(slot_sel) - 32'(slot_base);
          if (32'(slot_sel) >= 32'(slot_base) && slot_gap < 7) begin
            // The sought slot lies in this mask byte.
            if (!b[slot_gap[2:0]]) begin
              done = 1'b1;
              emit = 1'b1;
            end else begin
              present_cnt = present_cnt + ones_below(b[6:0], int'(slot_gap));
              if (b[7]) ph = pbfl_pkg::PH_DRAIN;
              else close_mask();
            end
          end else begin
            // A mask byte wholly below the slot: count it all and move on.
            present_cnt = present_cnt + ones_below(b[6:0], 7);
            slot_base   = slot_base + 17'd7;
            if (!b[7]) begin
              done = 1'b1;
              emit = 1'b1;
            end
          end
        end
        pbfl_pkg::PH_DRAIN: begin
          if (!b[7]) close_mask();
        end
        pbfl_pkg::PH_SKIP: begin
          byte_cnt = byte_cnt + 18'd1;
          if (32'(byte_cnt) >= 2 * 32'(present_cnt)) ph = pbfl_pkg::PH_OFF_LO;
        end
        pbfl_pkg::PH_OFF_LO: begin
          off_lo = b;
          ph     = pbfl_pkg::PH_OFF_HI;
        end
        pbfl_pkg::PH_OFF_HI: begin
          r.found        = 1'b1;
          r.field_offset = 33'(base) + 33'({b, off_lo});
          done           = 1'b1;
          emit           = 1'b1;
        end
        default: begin
          done = 1'b1;
          emit = 1'b1;
        end
      endcase
      // A record cut short still gets its not-found answer on the last byte.
      if (!done && is_last) begin
        done = 1'b1;
        emit = 1'b1;
      end
    end
    if (emit) offset_q.push_back(r);
    if (is_last) new_record();
  endtask

  // Compare one result word with the oldest expectation.
  task automatic check_result();
    locate_result_t exp_r;
    if (offset_q.size() == 0) begin
      $error("result word with nothing expected: found %0b field_offset 0x%0h",
             out_tuser, out_tdata[32:0]);
      mismatches++;
    end else begin
      exp_r = offset_q.pop_front();
      checked++;
      if (out_tuser !== exp_r.found) begin
        $error("found: expected %0b, got %0b", exp_r.found, out_tuser);
        mismatches++;
      end
      if (out_tdata[32:0] !== exp_r.field_offset) begin
        $error("field_offset: expected 0x%0h, got 0x%0h", exp_r.field_offset,
               out_tdata[32:0]);
        mismatches++;
      end
      if (out_tdata[39:33] !== 7'd0) begin
        $error("tdata padding: expected 0x0, got 0x%0h", out_tdata[39:33]);
        mismatches++;
      end
    end
  endtask

  // Results leave from a register loaded by their byte, so check before taking the new byte.
  // A slot write takes effect from the byte after the one taken at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      slot_sel = '0;
      new_record();
      offset_q.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) advance_locator(in_tdata[7:0], in_tdata[39:8], in_tlast);
      if (cfg_wr_en) slot_sel = cfg_wr_data;
    end
    pending = offset_q.size();
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int HdrBytes    = pbfl_pkg::HeaderBytesDflt;
  localparam int LimitCycles = 1_000_000;
  localparam int PhaseBytes  = 100;

  typedef logic [7:0] byte_q_t[$];
  typedef enum {REC_RANDOM, REC_INTACT, REC_NOISE} rec_shape_t;
  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [7:0] data_byte, [39:8] record_base
  logic        in_tlast;   // last_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [32:0] field_offset, [39:33] zero
  logic        out_tuser;  // [0] found
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  int pending;
  int mismatches;
  int checked;
  int send_idle_pct;
  int stall_pct;
  int cycles;
  int bytes_sent;
  int records_sent;
  int slot_writes;

  presence_bitmask_field_locator_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  field_locator_checker locator_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pending     (pending),
    .mismatches  (mismatches),
    .checked     (checked)
  );

  // Clock: 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LimitCycles) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic set_idle(input idle_mode_t m);
    case (m)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 86;
        stall_pct     = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct     = 86;
      end
      default: begin
        send_idle_pct = 7;
        stall_pct     = 7;
      end
    endcase
  endtask

  // Offer one byte word and hold it until the block takes it.
  task automatic send_word(input logic [7:0] b, input logic [31:0] base, input logic is_last);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {base, b};
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_record(input byte_q_t rec, input logic [31:0] base, input bit vary_base);
    foreach (rec[i]) begin
      send_word(rec[i], vary_base ? $urandom() : base, i == rec.size() - 1);
    end
    records_sent++;
  endtask

  // Build a record: header, bitmask, offset table, offset and some trailing bytes, or noise.
  task automatic build_record(input int slot, input int density, input rec_shape_t shape,
                              output byte_q_t rec);
    int         n_mask;
    int         present;
    int         cut;
    int         s;
    logic [6:0] bits;
    rec = {};
    if (shape == REC_NOISE || (shape == REC_RANDOM && $urandom_range(0, 99) < 6)) begin
      repeat ($urandom_range(1, 20)) rec.push_back(8'($urandom()));
    end else begin
      repeat (HdrBytes) rec.push_back(8'($urandom()));
      n_mask = slot / 7 + 1;
      if (shape == REC_RANDOM && n_mask > 1 && $urandom_range(0, 99) < 10) begin
        // The bitmask stops before it reaches the slot.
        n_mask = $urandom_range(1, n_mask - 1);
      end else if (shape == REC_RANDOM) begin
        n_mask = n_mask + $urandom_range(0, 2);
      end
      present = 0;
      for (int i = 0; i < n_mask; i++) begin
        for (int j = 0; j < 7; j++) begin
          s = i * 7 + j;
          if (s == slot) bits[j] = (shape == REC_INTACT) || ($urandom_range(0, 99) < 85);
          else bits[j] = ($urandom_range(0, 99) < density);
          if (s < slot && bits[j]) present++;
        end
        rec.push_back({i < n_mask - 1, bits});
      end
      repeat (2 * present + 2) rec.push_back(8'($urandom()));
      if (shape == REC_RANDOM) begin
        // Bytes after the answer, then now and then a cut anywhere in the record.
        repeat ($urandom_range(0, 3)) rec.push_back(8'($urandom()));
        if ($urandom_range(0, 99) < 10) begin
          cut = $urandom_range(1, rec.size());
          while (rec.size() > cut) void'(rec.pop_back());
        end
      end
    end
  endtask

  // Let the block drain completely, then write the slot register.
  task automatic write_slot(input logic [15:0] slot);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= slot;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    slot_writes++;
  endtask

  task automatic run_phase(input int slot, input idle_mode_t m);
    byte_q_t rec;
    int      start_bytes;
    int      density;
    write_slot(16'(slot));
    set_idle(m);
    start_bytes = bytes_sent;
    if (slot > 1000) begin
      // Records laid out for near slots, so every bitmask ends long before the far slot.
      repeat (6) begin
        build_record($urandom_range(0, 40), $urandom_range(0, 100), REC_RANDOM, rec);
        send_record(rec, $urandom(), 1'b0);
      end
      repeat (3) begin
        build_record(slot, 0, REC_NOISE, rec);
        send_record(rec, $urandom(), 1'b0);
      end
    end else begin
      while (bytes_sent - start_bytes < PhaseBytes) begin
        case ($urandom_range(0, 3))
          0: density = 0;
          1: density = 100;
          default: density = $urandom_range(10, 90);
        endcase
        build_record(slot, density, REC_RANDOM, rec);
        send_record(rec, $urandom(), $urandom_range(0, 9) == 0);
      end
    end
  endtask

  initial begin
    byte_q_t rec;
    int      slot_plan[10];
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    out_tready    = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    slot_plan     = '{0, 6, 7, 13, 1, 20, -1, 3, 65535, -1};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Slot 0 from reset: present with the largest base and offset.
    rec = {};
    repeat (HdrBytes) rec.push_back(8'h00);
    rec.push_back(8'h01);
    rec.push_back(8'hFF);
    rec.push_back(8'hFF);
    send_record(rec, 32'hFFFF_FFFF, 1'b0);

    // Slot 0 absent, followed by a byte the block must ignore.
    rec = {};
    repeat (HdrBytes) rec.push_back(8'hFF);
    rec.push_back(8'h7E);
    rec.push_back(8'hAA);
    send_record(rec, 32'h0000_0000, 1'b0);

    // A record cut short inside its header.
    rec = {};
    repeat (3) rec.push_back(8'h55);
    send_record(rec, 32'h8000_0001, 1'b0);

    // Random records under several slot settings and idle patterns.
    for (int p = 0; p < 10; p++) begin
      if (slot_plan[p] < 0) slot_plan[p] = $urandom_range(0, 40);
      run_phase(slot_plan[p], idle_mode_t'(p % 4));
    end

    write_slot(16'd0);
    repeat (10) @(negedge clk);

    $display("%0d bytes in %0d records sent, %0d result words checked", bytes_sent,
             records_sent, checked);
    $display("%0d slot register writes from 0 to 65535, under four idle patterns",
             slot_writes);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
